// ----- src/cbp_pkg.sv -----
// Package for the coefficient byte gearbox: field widths, register indexes,
// shared types and the coefficient width clamp. No dependencies.
package cbp_pkg;

    localparam int COEFF_W = 12;
    localparam int BYTE_W = 8;
    localparam int CWID_W = 4;
    localparam int BUF_W = 19;
    localparam int HELD_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int DEF_BLOCK_COEFFS = 256;
    localparam logic [COEFF_W-1:0] MODULUS = 12'd3329;
    localparam logic [CWID_W-1:0] MAX_WIDTH = 4'd12;
    localparam logic [CWID_W-1:0] RESET_WIDTH = 4'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd1;

    typedef enum logic {
        DIR_PACK = 1'b0,
        DIR_UNPACK = 1'b1
    } t_dir;

    typedef struct packed {
        logic [CWID_W-1:0] width;
        t_dir dir;
        logic clear;
    } t_cfg;

    typedef struct packed {
        logic [COEFF_W-1:0] out_value;
        logic last;
    } t_result;

    function automatic logic [CWID_W-1:0] eff_width(input logic [CWID_W-1:0] raw);
        logic [CWID_W-1:0] w;
        w = raw;
        if (raw == '0) begin
            w = 4'd1;
        end else if (raw > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        return w;
    endfunction

endpackage

// ----- src/cbp_ifs.sv -----
// Valid/ready channel interfaces of the coefficient byte gearbox.
// Depends on cbp_pkg for the field widths.
interface cbp_coeff_if;
    import cbp_pkg::*;
    logic valid;
    logic ready;
    logic [COEFF_W-1:0] coeff_in;
    logic [BYTE_W-1:0] byte_in;
    modport source (output valid, output coeff_in, output byte_in, input ready);
    modport sink (input valid, input coeff_in, input byte_in, output ready);
endinterface

interface cbp_result_if;
    import cbp_pkg::*;
    logic valid;
    logic ready;
    logic [COEFF_W-1:0] out_value;
    logic last;
    modport source (output valid, output out_value, output last, input ready);
    modport sink (input valid, input out_value, input last, output ready);
endinterface

interface cbp_cfg_if;
    import cbp_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/cbp_cfg_regs.sv -----
// Configuration registers of the gearbox: coefficient width and direction.
// Depends on cbp_pkg for register indexes and the t_cfg struct.
module cbp_cfg_regs
    import cbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_wr_ready,
    output t_cfg                  o_cfg
);

    logic [CWID_W-1:0] r_width;
    t_dir r_dir;
    logic wr_fire;

    assign o_wr_ready = 1'b1;
    assign wr_fire = i_wr_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RESET_WIDTH;
            r_dir <= DIR_PACK;
        end else if (wr_fire) begin
            case (i_wr_index)
                CFG_COEFF_WIDTH: r_width <= i_wr_data[CWID_W-1:0];
                CFG_DIRECTION:   r_dir <= t_dir'(i_wr_data[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.width = eff_width(r_width);
        o_cfg.dir = r_dir;
        o_cfg.clear = wr_fire && (i_wr_index == CFG_COEFF_WIDTH
                                  || i_wr_index == CFG_DIRECTION);
    end

endmodule

// ----- src/cbp_gearbox.sv -----
// Bit buffer of the gearbox: hands out one result per cycle while i_res_free is
// high, takes in a request once no complete results remain. Depends on cbp_pkg.
module cbp_gearbox
    import cbp_pkg::*;
#(
    parameter int BLOCK_COEFFS = DEF_BLOCK_COEFFS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic [COEFF_W-1:0] i_coeff,
    input  logic [BYTE_W-1:0]  i_byte,
    output logic               o_ready,
    input  logic               i_res_free,
    output logic               o_res_valid,
    output t_result            o_res
);

    localparam int IDX_W = $clog2(BLOCK_COEFFS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_COEFFS - 1);

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [HELD_W-1:0] r_held, n_held;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic r_fin, n_fin;

    logic [BUF_W-1:0] buf1;
    logic [HELD_W-1:0] held1;
    logic [IDX_W-1:0] idx1;
    logic fin1;
    logic [HELD_W-1:0] d_ext;
    logic [COEFF_W-1:0] mask;
    logic [COEFF_W-1:0] raw_coeff;
    logic pending;
    logic emit;
    logic absorb;

    assign d_ext = HELD_W'(i_cfg.width);
    assign mask = COEFF_W'((13'd1 << i_cfg.width) - 13'd1);
    assign raw_coeff = r_buf[COEFF_W-1:0] & mask;

    always_comb begin
        if (i_cfg.dir == DIR_PACK) begin
            pending = (r_held >= HELD_W'(8)) || r_fin;
        end else begin
            pending = (r_held >= d_ext);
        end
    end

    assign emit = pending && i_res_free;
    assign o_res_valid = emit;

    always_comb begin
        buf1 = r_buf;
        held1 = r_held;
        idx1 = r_idx;
        fin1 = r_fin;
        o_res.out_value = '0;
        o_res.last = 1'b0;
        if (emit) begin
            if (i_cfg.dir == DIR_PACK) begin
                o_res.out_value = COEFF_W'(r_buf[BYTE_W-1:0]);
                if (r_held >= HELD_W'(8)) begin
                    o_res.last = r_fin && (r_held == HELD_W'(8));
                    buf1 = r_buf >> 8;
                    held1 = r_held - HELD_W'(8);
                end else begin
                    o_res.last = 1'b1;
                end
                if (o_res.last) begin
                    buf1 = '0;
                    held1 = '0;
                    fin1 = 1'b0;
                end
            end else begin
                if (i_cfg.width == MAX_WIDTH && raw_coeff >= MODULUS) begin
                    o_res.out_value = raw_coeff - MODULUS;
                end else begin
                    o_res.out_value = raw_coeff;
                end
                buf1 = r_buf >> i_cfg.width;
                held1 = r_held - d_ext;
                if (r_idx == IDX_LAST) begin
                    o_res.last = 1'b1;
                    buf1 = '0;
                    held1 = '0;
                    idx1 = '0;
                end else begin
                    idx1 = IDX_W'(r_idx + 1'b1);
                end
            end
        end
    end

    always_comb begin
        if (i_cfg.dir == DIR_PACK) begin
            o_ready = (held1 < HELD_W'(8)) && !fin1;
        end else begin
            o_ready = (held1 < d_ext);
        end
    end

    assign absorb = i_valid && o_ready;

    always_comb begin
        n_buf = buf1;
        n_held = held1;
        n_idx = idx1;
        n_fin = fin1;
        if (i_cfg.clear) begin
            n_buf = '0;
            n_held = '0;
            n_idx = '0;
            n_fin = 1'b0;
        end else if (absorb) begin
            if (i_cfg.dir == DIR_PACK) begin
                n_buf = buf1 | (BUF_W'(i_coeff & mask) << held1);
                n_held = held1 + d_ext;
                if (idx1 == IDX_LAST) begin
                    n_idx = '0;
                    n_fin = 1'b1;
                end else begin
                    n_idx = IDX_W'(idx1 + 1'b1);
                end
            end else begin
                n_buf = buf1 | (BUF_W'(i_byte) << held1);
                n_held = held1 + HELD_W'(8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_held <= '0;
            r_idx <= '0;
            r_fin <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_held <= n_held;
            r_idx <= n_idx;
            r_fin <= n_fin;
        end
    end

endmodule

// ----- src/cbp_out_reg.sv -----
// Output register of the gearbox: holds one result until the sink takes it.
// Depends on cbp_pkg for the t_result struct.
module cbp_out_reg
    import cbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_result            i_res,
    output logic               o_free,
    output logic               o_valid,
    output logic [COEFF_W-1:0] o_out_value,
    output logic               o_last,
    input  logic               i_ready
);

    logic r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_out_value = r_res.out_value;
    assign o_last = r_res.last;

endmodule

// ----- src/coefficient_byte_pack_unpack.sv -----
// Coefficient byte gearbox between d-bit coefficients and bytes, LSB first,
// in blocks of BLOCK_COEFFS coefficients. A request is taken at the same clock
// edge at which the previous request's last complete result moves to the output
// register, so no new request is taken while complete results of the previous
// one remain (up to three bytes in pack mode, up to eight coefficients in
// unpack mode with d = 1). Results appear in the cycle after they are formed.
// Write configuration only while no results are outstanding; every write to
// the width or direction register restarts the block. Depends on cbp_pkg,
// cbp_ifs, cbp_cfg_regs, cbp_gearbox and cbp_out_reg.
module coefficient_byte_pack_unpack
    import cbp_pkg::*;
#(
    parameter int BLOCK_COEFFS = DEF_BLOCK_COEFFS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbp_coeff_if.sink    i_coeff,
    cbp_result_if.source o_result,
    cbp_cfg_if.sink      i_cfg
);

    t_cfg cfg;
    t_result res;
    logic res_valid;
    logic res_free;
    logic cfg_ready;
    logic in_ready;
    logic out_valid;
    logic [COEFF_W-1:0] out_value;
    logic out_last;

    cbp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (cfg_ready),
        .o_cfg      (cfg)
    );

    cbp_gearbox #(
        .BLOCK_COEFFS (BLOCK_COEFFS)
    ) u_gearbox (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_coeff.valid),
        .i_coeff     (i_coeff.coeff_in),
        .i_byte      (i_coeff.byte_in),
        .o_ready     (in_ready),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cbp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (res_valid),
        .i_res       (res),
        .o_free      (res_free),
        .o_valid     (out_valid),
        .o_out_value (out_value),
        .o_last      (out_last),
        .i_ready     (o_result.ready)
    );

    assign i_cfg.ready = cfg_ready;
    assign i_coeff.ready = in_ready;
    assign o_result.valid = out_valid;
    assign o_result.out_value = out_value;
    assign o_result.last = out_last;

endmodule

// ----- src/cbp_checker.sv -----
// Port-level checks for the coefficient byte gearbox, bound to the top level.
// Depends on cbp_pkg for widths, register indexes and the modulus.
module cbp_checker
    import cbp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  i_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COEFF_W-1:0]    i_out_value,
    input logic                  i_out_last
);

    logic [CWID_W-1:0] r_width;
    logic r_unpack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RESET_WIDTH;
            r_unpack <= 1'b0;
        end else if (i_cfg_valid && i_cfg_ready) begin
            if (i_cfg_index == CFG_COEFF_WIDTH) begin
                r_width <= i_cfg_data[CWID_W-1:0];
            end
            if (i_cfg_index == CFG_DIRECTION) begin
                r_unpack <= i_cfg_data[0];
            end
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result changed");

    a_pack_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_unpack |-> i_out_value[COEFF_W-1:BYTE_W] == '0)
        else $error("packed result wider than a byte");

    a_unpack_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_unpack && r_width >= MAX_WIDTH |-> i_out_value < MODULUS)
        else $error("unpacked coefficient not reduced");

endmodule

bind coefficient_byte_pack_unpack cbp_checker u_cbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.out_value),
    .i_out_last  (o_result.last)
);

// ----- test/tb.sv -----
// Testbench for the coefficient byte gearbox: directed table then random pack and unpack
// phases, each result checked in order against typed values or a bit-level predictor.
// Depends on cbp_pkg, the channel interfaces in cbp_ifs and coefficient_byte_pack_unpack.
`timescale 1ns / 1ps

module tb;
    import cbp_pkg::*;

    localparam int BLOCK_COEFFS = DEF_BLOCK_COEFFS;
    localparam int PREDICT = -1;
    localparam int DRAIN = 4;
    localparam int HOLD_AT = 100;
    localparam int LONG_HOLD = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 50;
    localparam int unsigned BUF_MASK = (1 << BUF_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bit is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [COEFF_W-1:0] coeff;
        logic [BYTE_W-1:0] bval;
        int n_typed;
        t_result r0;
        t_result r1;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cbp_coeff_if coeff_ch ();
    cbp_result_if res_ch ();
    cbp_cfg_if cfg_ch ();

    coefficient_byte_pack_unpack #(
        .BLOCK_COEFFS(BLOCK_COEFFS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coeff (coeff_ch),
        .o_result(res_ch),
        .i_cfg   (cfg_ch)
    );

    logic [CWID_W-1:0] model_width;
    t_dir model_dir;
    int unsigned model_bits;
    int unsigned model_held;
    int unsigned model_count;

    t_result step_out[$];
    t_result pending_results[$];
    int mismatches;
    int items_accepted;
    int cycle_count;
    bit quiet;
    bit long_hold_done;

    function automatic t_result mk_result(input int unsigned v, input bit l);
        t_result r;
        r.out_value = COEFF_W'(v);
        r.last = l;
        return r;
    endfunction

    function automatic void clear_stream();
        model_bits = 0;
        model_held = 0;
        model_count = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_COEFF_WIDTH) begin
            model_width = data[CWID_W-1:0];
            clear_stream();
        end else if (idx == CFG_DIRECTION) begin
            model_dir = t_dir'(data[0]);
            clear_stream();
        end
    endfunction

    function automatic void gearbox_step(input logic [COEFF_W-1:0] coeff,
                                         input logic [BYTE_W-1:0] bval);
        int unsigned d;
        int unsigned mask;
        int unsigned v;
        bit block_end;
        step_out.delete();
        d = (model_width == 0) ? 1 : ((model_width > 12) ? 12 : model_width);
        mask = (1 << d) - 1;
        if (model_dir == DIR_PACK) begin
            model_bits = (model_bits | ((int'(coeff) & mask) << model_held)) & BUF_MASK;
            model_held += d;
            model_count++;
            block_end = model_count >= BLOCK_COEFFS;
            while (model_held >= 8) begin
                step_out.push_back(mk_result(model_bits & 8'hFF, block_end && model_held == 8));
                model_bits >>= 8;
                model_held -= 8;
            end
            if (block_end) begin
                if (model_held > 0) begin
                    step_out.push_back(mk_result(model_bits & 8'hFF, 1'b1));
                end
                clear_stream();
            end
        end else begin
            model_bits = (model_bits | (int'(bval) << model_held)) & BUF_MASK;
            model_held += 8;
            while (model_held >= d) begin
                v = model_bits & mask;
                if (d == 12) begin
                    v = v % int'(MODULUS);
                end
                model_bits >>= d;
                model_held -= d;
                model_count++;
                if (model_count >= BLOCK_COEFFS) begin
                    step_out.push_back(mk_result(v, 1'b1));
                    clear_stream();
                    break;
                end
                step_out.push_back(mk_result(v, 1'b0));
            end
        end
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        r.coeff = '0;
        r.bval = '0;
        r.n_typed = PREDICT;
        r.r0 = '0;
        r.r1 = '0;
        return r;
    endfunction

    function automatic t_row item_row(input logic [COEFF_W-1:0] coeff,
                                      input logic [BYTE_W-1:0] bval, input int n,
                                      input int unsigned v0, input bit l0,
                                      input int unsigned v1, input bit l1);
        t_row r;
        r.is_reg = 1'b0;
        r.reg_idx = '0;
        r.reg_data = '0;
        r.coeff = coeff;
        r.bval = bval;
        r.n_typed = n;
        r.r0 = mk_result(v0, l0);
        r.r1 = mk_result(v1, l1);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic wait_idle();
        coeff_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input logic [COEFF_W-1:0] coeff, input logic [BYTE_W-1:0] bval,
                             input int n_typed, input t_result r0, input t_result r1);
        if (!quiet && (items_accepted / 48) % 3 != 2 && $urandom_range(0, 3) == 0) begin
            coeff_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        coeff_ch.valid <= 1'b1;
        coeff_ch.coeff_in <= coeff;
        coeff_ch.byte_in <= bval;
        do @(posedge i_clk); while (!coeff_ch.ready);
        items_accepted++;
        gearbox_step(coeff, bval);
        if (n_typed == PREDICT) begin
            foreach (step_out[k]) pending_results.push_back(step_out[k]);
        end else begin
            if (n_typed > 0) pending_results.push_back(r0);
            if (n_typed > 1) pending_results.push_back(r1);
        end
    endtask

    task automatic send_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                wait_idle();
            end
            send_item(COEFF_W'($urandom), BYTE_W'($urandom), PREDICT, '0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d last %0b",
                                          res_ch.out_value, res_ch.last));
            end else begin
                want = pending_results.pop_front();
                if (res_ch.out_value !== want.out_value) begin
                    report_mismatch($sformatf("out_value %0d, expected %0d",
                                              res_ch.out_value, want.out_value));
                end
                if (res_ch.last !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              res_ch.last, want.last));
                end
            end
        end
    end

    initial begin : result_sink
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && items_accepted >= HOLD_AT) begin
                long_hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (!quiet && (cycle_count / 200) % 3 != 2 &&
                         $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_row dir_tab[$];
        int wait_cycles;
        i_rst_n = 1'b0;
        coeff_ch.valid = 1'b0;
        coeff_ch.coeff_in = '0;
        coeff_ch.byte_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        mismatches = 0;
        items_accepted = 0;
        cycle_count = 0;
        quiet = 1'b0;
        long_hold_done = 1'b0;
        model_width = RESET_WIDTH;
        model_dir = DIR_PACK;
        clear_stream();

        dir_tab.push_back(item_row(12'hFFF, 8'h00, 1, 12'h0FF, 1'b0, 0, 1'b0));
        dir_tab.push_back(item_row(12'h000, 8'hFF, 2, 12'h00F, 1'b0, 12'h000, 1'b0));
        dir_tab.push_back(item_row(12'hABC, 8'h5A, PREDICT, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_DIRECTION, CFG_DATA_W'(DIR_UNPACK)));
        dir_tab.push_back(item_row(12'h000, 8'hFF, 0, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(item_row(12'hFFF, 8'hFF, 1, 766, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_COEFF_WIDTH, 4'd12));
        dir_tab.push_back(item_row(12'h000, 8'h01, 0, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(item_row(12'h000, 8'h0D, 1, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(item_row(12'h000, 8'hD0, 1, 3328, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_COEFF_WIDTH, 4'd0));
        dir_tab.push_back(item_row(12'hFFF, 8'hA5, PREDICT, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_COEFF_WIDTH, 4'd15));
        dir_tab.push_back(item_row(12'h000, 8'hFF, 0, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_UNUSED, 4'hF));
        dir_tab.push_back(item_row(12'h000, 8'hFF, 1, 766, 1'b0, 0, 1'b0));
        dir_tab.push_back(item_row(12'h000, 8'h80, PREDICT, 0, 1'b0, 0, 1'b0));
        dir_tab.push_back(reg_row(CFG_DIRECTION, CFG_DATA_W'(DIR_PACK)));
        dir_tab.push_back(reg_row(CFG_COEFF_WIDTH, 4'd1));
        for (int k = 0; k < 8; k++) begin
            dir_tab.push_back(item_row((k % 2 == 1) ? 12'hFFE : 12'hFFF, BYTE_W'($urandom),
                                       (k == 7) ? 1 : 0, 12'h055, 1'b0, 0, 1'b0));
        end
        dir_tab.push_back(reg_row(CFG_COEFF_WIDTH, 4'd13));
        dir_tab.push_back(item_row(12'hFFF, 8'h00, 1, 12'h0FF, 1'b0, 0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_reg) begin
                write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_data);
            end else begin
                send_item(dir_tab[r].coeff, dir_tab[r].bval, dir_tab[r].n_typed,
                          dir_tab[r].r0, dir_tab[r].r1);
            end
        end

        // A full packing block, with a drain partway through.
        write_reg(CFG_COEFF_WIDTH, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_PACK));
        send_random(BLOCK_COEFFS, 180);

        write_reg(CFG_COEFF_WIDTH, 4'd1);
        write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_UNPACK));
        send_random(40, -1);

        for (int p = 0; p < 2; p++) begin
            write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_UNPACK));
            write_reg(CFG_COEFF_WIDTH, CFG_DATA_W'($urandom_range(0, 15)));
            send_random($urandom_range(8, 16), -1);
        end

        quiet = 1'b1;
        write_reg(CFG_COEFF_WIDTH, 4'd2);
        send_random(40, -1);

        coeff_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4 * DRAIN) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
